>>> sv/csvlp_pkg.sv
// ----------------------------------------------------------------------------
// CSV line parser package
// Shared payload types, result codes, character constants and helpers.
// ----------------------------------------------------------------------------
package csvlp_pkg;

	localparam int FIELD_COUNT_MAX_DEF = 255;
	localparam int QUEUE_DEPTH_DEF     = 4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_EOF  = 2'd1;
	localparam logic [1:0] KIND_EOL  = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_UNTERM   = 2'd1;
	localparam logic [1:0] ERR_JUNK     = 2'd2;

	typedef enum logic [2:0] {
		PH_START,
		PH_UNQ,
		PH_QUO,
		PH_QQ,
		PH_AFTER,
		PH_DONE,
		PH_ERR
	} phase_t;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_mark;
	} in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [7:0] field_index;
		logic [1:0] error_code;
		logic       last;
	} res_t;

	// One queue entry: the one or two results caused by a single input byte.
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} entry_t;

	function automatic res_t mk_res(logic [1:0] kind, logic [7:0] data_byte,
			logic [7:0] field_index, logic [1:0] error_code);
		res_t r;
		r.kind        = kind;
		r.data_byte   = data_byte;
		r.field_index = field_index;
		r.error_code  = error_code;
		r.last        = 1'b0;
		return r;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
	endfunction

endpackage

>>> sv/csvlp_front.sv
// ----------------------------------------------------------------------------
// CSV line parser front end
// Accepts bytes, runs the parse state machine, emits result entries.
// ----------------------------------------------------------------------------
module csvlp_front #(
	parameter int FIELD_COUNT_MAX = csvlp_pkg::FIELD_COUNT_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  csvlp_pkg::in_t     item,
	output logic               push,
	output csvlp_pkg::entry_t  entry
);
	import csvlp_pkg::*;

	localparam logic [7:0] CAP = (FIELD_COUNT_MAX < 255) ? 8'(FIELD_COUNT_MAX) : 8'd255;

	phase_t     phase_q, phase_nxt;
	logic [7:0] fd_q, fd_nxt;
	logic [7:0] fd_inc;
	logic       have0, have1;
	logic       is_nl;
	res_t       r0, r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			fd_q    <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			fd_q    <= fd_nxt;
		end
	end

	always_comb begin
		fd_inc    = (fd_q < CAP) ? fd_q + 8'd1 : fd_q;
		is_nl     = (item.char_in == CH_LF) || (item.char_in == CH_CR);
		phase_nxt = phase_q;
		fd_nxt    = fd_q;
		have0     = 1'b0;
		have1     = 1'b0;
		r0        = mk_res(KIND_BYTE, 8'd0, fd_q, ERR_NONE);
		r1        = mk_res(KIND_BYTE, 8'd0, fd_q, ERR_NONE);
		if (item.end_mark) begin
			case (phase_q)
				PH_START: begin
					have0 = 1'b1;
					if (fd_q == 8'd0) begin
						have1 = 1'b1;
						r0    = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
						r1    = mk_res(KIND_EOL, 8'd0, fd_inc, ERR_NONE);
					end else begin
						r0    = mk_res(KIND_EOL, 8'd0, fd_q, ERR_NONE);
					end
				end
				PH_UNQ, PH_QQ, PH_AFTER: begin
					have0 = 1'b1;
					have1 = 1'b1;
					r0    = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
					r1    = mk_res(KIND_EOL, 8'd0, fd_inc, ERR_NONE);
				end
				PH_QUO: begin
					have0 = 1'b1;
					r0    = mk_res(KIND_ERR, 8'd0, fd_q, ERR_UNTERM);
				end
				default: begin
				end
			endcase
			phase_nxt = PH_START;
			fd_nxt    = 8'd0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (item.char_in == CH_QUOTE) begin
						phase_nxt = PH_QUO;
					end else if (item.char_in == CH_COMMA) begin
						have0  = 1'b1;
						r0     = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
						fd_nxt = fd_inc;
					end else if (is_nl) begin
						have0     = 1'b1;
						phase_nxt = PH_DONE;
						if (fd_q == 8'd0) begin
							have1  = 1'b1;
							r0     = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
							r1     = mk_res(KIND_EOL, 8'd0, fd_inc, ERR_NONE);
							fd_nxt = fd_inc;
						end else begin
							r0     = mk_res(KIND_EOL, 8'd0, fd_q, ERR_NONE);
						end
					end else begin
						have0     = 1'b1;
						r0        = mk_res(KIND_BYTE, item.char_in, fd_q, ERR_NONE);
						phase_nxt = PH_UNQ;
					end
				end
				PH_UNQ: begin
					have0 = 1'b1;
					if (item.char_in == CH_COMMA) begin
						r0        = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
						fd_nxt    = fd_inc;
						phase_nxt = PH_START;
					end else if (is_nl) begin
						have1     = 1'b1;
						r0        = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
						r1        = mk_res(KIND_EOL, 8'd0, fd_inc, ERR_NONE);
						fd_nxt    = fd_inc;
						phase_nxt = PH_DONE;
					end else begin
						r0        = mk_res(KIND_BYTE, item.char_in, fd_q, ERR_NONE);
					end
				end
				PH_QUO: begin
					if (item.char_in == CH_QUOTE) begin
						phase_nxt = PH_QQ;
					end else begin
						have0 = 1'b1;
						r0    = mk_res(KIND_BYTE, item.char_in, fd_q, ERR_NONE);
					end
				end
				PH_QQ, PH_AFTER: begin
					if ((phase_q == PH_QQ) && (item.char_in == CH_QUOTE)) begin
						// A doubled quote stands for one quote byte.
						have0     = 1'b1;
						r0        = mk_res(KIND_BYTE, item.char_in, fd_q, ERR_NONE);
						phase_nxt = PH_QUO;
					end else if (item.char_in == CH_COMMA) begin
						have0     = 1'b1;
						r0        = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
						fd_nxt    = fd_inc;
						phase_nxt = PH_START;
					end else if (is_nl) begin
						have0     = 1'b1;
						have1     = 1'b1;
						r0        = mk_res(KIND_EOF, 8'd0, fd_q, ERR_NONE);
						r1        = mk_res(KIND_EOL, 8'd0, fd_inc, ERR_NONE);
						fd_nxt    = fd_inc;
						phase_nxt = PH_DONE;
					end else if (is_blank(item.char_in)) begin
						phase_nxt = PH_AFTER;
					end else begin
						have0     = 1'b1;
						r0        = mk_res(KIND_ERR, 8'd0, fd_q, ERR_JUNK);
						phase_nxt = PH_ERR;
					end
				end
				default: begin
				end
			endcase
		end
		r0.last   = ~have1;
		r1.last   = 1'b1;
		entry.r0  = r0;
		entry.r1  = r1;
		entry.two = have1;
		push      = accept & have0;
	end

endmodule

>>> sv/csvlp_queue.sv
// ----------------------------------------------------------------------------
// CSV line parser entry queue
// Small register FIFO between the parse front end and the output back end.
// ----------------------------------------------------------------------------
module csvlp_queue #(
	parameter int DEPTH = csvlp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  csvlp_pkg::entry_t  wr_entry,
	input  logic               pop,
	output csvlp_pkg::entry_t  head,
	output logic               nonempty,
	output logic               full
);
	import csvlp_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head     = mem_q[rd_ptr_q];
	assign nonempty = (count_q != '0);
	assign full     = (count_q == CW'(DEPTH));

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with unequal pointers");

endmodule

>>> sv/csvlp_back.sv
// ----------------------------------------------------------------------------
// CSV line parser back end
// Unpacks queue entries into single results held in an output register.
// ----------------------------------------------------------------------------
module csvlp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  csvlp_pkg::entry_t  head,
	input  logic               nonempty,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_stall,
	output csvlp_pkg::res_t    res_data
);
	import csvlp_pkg::*;

	logic valid_q;
	logic half_q;
	res_t res_q;
	logic load;

	assign load = nonempty && (!valid_q || !res_stall);
	assign pop  = load && (!head.two || half_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			half_q  <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			half_q  <= head.two && !half_q;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= half_q ? head.r1 : head.r0;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = res_q;

endmodule

>>> sv/csv_line_field_parser_core.sv
// ----------------------------------------------------------------------------
// CSV line field parser core
// Splits one CSV line per end marker into field bytes, field, line and error marks.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+---------------------------------
//  byte    | in        | byte_valid/byte_stall | char_in, end_mark
//  res     | out       | res_valid/res_stall   | kind, data_byte, field_index,
//          |           |                       | error_code, last
//
// One input byte is taken per cycle while the entry queue has room; the parse
// state machine in the front end decides each byte in the cycle it is taken.
// A byte causes zero, one or two results; the back end sends one result per
// cycle while res_stall is low; a two-result entry is popped with its second.
// Reset returns the parser to field start with a zero count and empties the
// queue and output register. A stall on the result side fills the queue and
// then raises byte_stall; the input side never holds back the output side.
//
module csv_line_field_parser_core #(
	parameter int FIELD_COUNT_MAX = csvlp_pkg::FIELD_COUNT_MAX_DEF,
	parameter int QUEUE_DEPTH     = csvlp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  csvlp_pkg::in_t   byte_data,
	output logic             res_valid,
	input  logic             res_stall,
	output csvlp_pkg::res_t  res_data
);
	import csvlp_pkg::*;

	// A byte transfer happens whenever the queue can take its entry. The
	// front end advances its state only on a transfer.
	logic   accept;
	logic   push;
	logic   pop;
	logic   nonempty;
	logic   full;
	entry_t wr_entry;
	entry_t head;

	assign byte_stall = full;
	assign accept     = byte_valid && !full;

	// Front end: the parse state machine and the field counter.
	csvlp_front #(
		.FIELD_COUNT_MAX(FIELD_COUNT_MAX)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (byte_data),
		.push   (push),
		.entry  (wr_entry)
	);

	// The queue decouples the byte side from the result side.
	csvlp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty),
		.full     (full)
	);

	// Back end: one result transfer per cycle, while res_stall is low, from a registered output.
	csvlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.nonempty  (nonempty),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

>>> bench/csv_line_field_parser_core_tb.sv
// ----------------------------------------------------------------------------
// CSV line field parser core testbench
// Sends CSV lines byte by byte. Each result transfer is checked against a
// tokenizer that runs alongside the core. The sender idles and the receiver
// stalls at random.
// ----------------------------------------------------------------------------
module csv_line_field_parser_core_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import csvlp_pkg::*;

	// The field counter saturates at the smaller of the parameter and 255.
	localparam int         DUT_FIELD_MAX = FIELD_COUNT_MAX_DEF;
	localparam logic [7:0] FIELD_CAP     = (DUT_FIELD_MAX < 255) ? 8'(DUT_FIELD_MAX) : 8'd255;
	localparam int         RANDOM_ITEMS  = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	in_t  byte_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	// Tokenizer state kept alongside the core, and the tokens it still expects.
	phase_t     tok_phase = PH_START;
	logic [7:0] tok_fields = '0;
	res_t       step_tokens[$];
	res_t       pending_tokens[$];

	// Sender and receiver idling state.
	int burst_left = 0;
	int stall_mode = 0;
	int stall_left = 0;

	// Run statistics.
	int n_errors = 0;
	int n_items = 0;
	int n_lines = 0;
	int n_checked = 0;
	int n_eol_seen = 0;
	int n_err_seen = 0;

	csv_line_field_parser_core #(
		.FIELD_COUNT_MAX(DUT_FIELD_MAX)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data (byte_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Tokenizer. Each accepted byte yields zero, one or two tokens. The last
	// token of a byte carries the last flag.
	// ------------------------------------------------------------------------
	function automatic bit blank_char(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
	endfunction

	function automatic void put_token(logic [1:0] k, logic [7:0] b, logic [7:0] idx,
			logic [1:0] e);
		res_t r;
		r.kind        = k;
		r.data_byte   = b;
		r.field_index = idx;
		r.error_code  = e;
		r.last        = 1'b0;
		step_tokens.push_back(r);
	endfunction

	// Closing a field reports its index. The count then steps up until it saturates.
	function automatic void field_done();
		put_token(KIND_EOF, 8'h00, tok_fields, ERR_NONE);
		if (tok_fields < FIELD_CAP)
			tok_fields++;
	endfunction

	// An empty line still holds one empty field.
	function automatic void line_done();
		if (tok_fields == 8'd0)
			field_done();
		put_token(KIND_EOL, 8'h00, tok_fields, ERR_NONE);
	endfunction

	// After a closing quote only blanks may come before the comma or the line break.
	function automatic void after_close(logic [7:0] c);
		if (c == CH_COMMA) begin
			field_done();
			tok_phase = PH_START;
		end else if (c == CH_LF || c == CH_CR) begin
			field_done();
			line_done();
			tok_phase = PH_DONE;
		end else if (blank_char(c)) begin
			tok_phase = PH_AFTER;
		end else begin
			put_token(KIND_ERR, 8'h00, tok_fields, ERR_JUNK);
			tok_phase = PH_ERR;
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] c, logic endm);
		step_tokens.delete();
		if (endm) begin
			case (tok_phase)
				PH_START: line_done();
				PH_UNQ, PH_QQ, PH_AFTER: begin
					field_done();
					line_done();
				end
				PH_QUO: put_token(KIND_ERR, 8'h00, tok_fields, ERR_UNTERM);
				default: ;
			endcase
			tok_phase  = PH_START;
			tok_fields = 8'd0;
		end else begin
			case (tok_phase)
				PH_START: begin
					if (c == CH_QUOTE) begin
						tok_phase = PH_QUO;
					end else if (c == CH_COMMA) begin
						field_done();
					end else if (c == CH_LF || c == CH_CR) begin
						line_done();
						tok_phase = PH_DONE;
					end else begin
						put_token(KIND_BYTE, c, tok_fields, ERR_NONE);
						tok_phase = PH_UNQ;
					end
				end
				PH_UNQ: begin
					if (c == CH_COMMA) begin
						field_done();
						tok_phase = PH_START;
					end else if (c == CH_LF || c == CH_CR) begin
						field_done();
						line_done();
						tok_phase = PH_DONE;
					end else begin
						// A quote inside an unquoted field is plain content.
						put_token(KIND_BYTE, c, tok_fields, ERR_NONE);
					end
				end
				PH_QUO: begin
					if (c == CH_QUOTE)
						tok_phase = PH_QQ;
					else
						put_token(KIND_BYTE, c, tok_fields, ERR_NONE);
				end
				PH_QQ: begin
					// A doubled quote gives one quote byte. Anything else
					// means the quote before it closed the field.
					if (c == CH_QUOTE) begin
						put_token(KIND_BYTE, c, tok_fields, ERR_NONE);
						tok_phase = PH_QUO;
					end else begin
						after_close(c);
					end
				end
				PH_AFTER: after_close(c);
				default: ;	// After a line break or an error, bytes are dropped.
			endcase
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].last = 1'b1;
		foreach (step_tokens[i])
			pending_tokens.push_back(step_tokens[i]);
	endfunction

	// ------------------------------------------------------------------------
	// Checking. Every result transfer is compared with the oldest pending token.
	// ------------------------------------------------------------------------
	task report_mismatch(input string what);
		n_errors++;
		if (n_errors <= 100)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			got = res_data;
			if (pending_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d index %0d",
					got.kind, got.field_index));
			end else begin
				want = pending_tokens.pop_front();
				if (got.kind !== want.kind)
					report_mismatch($sformatf("result %0d kind %0d, expected %0d",
						n_checked, got.kind, want.kind));
				if (got.data_byte !== want.data_byte)
					report_mismatch($sformatf("result %0d data_byte %h, expected %h",
						n_checked, got.data_byte, want.data_byte));
				if (got.field_index !== want.field_index)
					report_mismatch($sformatf("result %0d field_index %0d, expected %0d",
						n_checked, got.field_index, want.field_index));
				if (got.error_code !== want.error_code)
					report_mismatch($sformatf("result %0d error_code %0d, expected %0d",
						n_checked, got.error_code, want.error_code));
				if (got.last !== want.last)
					report_mismatch($sformatf("result %0d last %b, expected %b",
						n_checked, got.last, want.last));
				if (want.kind == KIND_EOL)
					n_eol_seen++;
				if (want.kind == KIND_ERR)
					n_err_seen++;
			end
			n_checked++;
		end
	end

	// ------------------------------------------------------------------------
	// Receiver. The stall mode is redrawn each time its random run length
	// runs out. It may be free running, sparse random, dense random, or a
	// fixed repeating rhythm.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(20, 200);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: res_stall <= 1'b0;
			1: res_stall <= ($urandom_range(0, 3) == 0);
			2: res_stall <= ($urandom_range(0, 1) == 0);
			default: res_stall <= ((stall_left % 8) < 5);
		endcase
	end

	// ------------------------------------------------------------------------
	// Sender. Bytes go out in bursts of random length with random gaps
	// between them. The task returns at the edge where the transfer happens,
	// so the next byte can follow at once without a drop in valid.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [7:0] c, input logic endm);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		byte_data  <= '{char_in: c, end_mark: endm};
		byte_valid <= 1'b1;
		do
			@(posedge clk);
		while (byte_stall !== 1'b0);
		tokenize_byte(c, endm);
		n_items++;
	endtask

	task automatic send_data(input logic [7:0] c);
		send_item(c, 1'b0);
	endtask

	// The byte that rides with the end marker is ignored, so it is random.
	task automatic send_end();
		send_item(8'($urandom_range(0, 255)), 1'b1);
		n_lines++;
	endtask

	task automatic send_str(input string s);
		foreach (s[i])
			send_data(s[i]);
	endtask

	// Hold off the sender until every pending token has come back. Valid
	// is dropped and stays low until the next byte goes out.
	task automatic wait_drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Byte pickers for the random lines.
	// ------------------------------------------------------------------------
	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	// Any byte that keeps an unquoted field open.
	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_COMMA || c == CH_LF || c == CH_CR);
		return c;
	endfunction

	// A byte that is not allowed after a closing quote.
	function automatic logic [7:0] pick_junk();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CH_COMMA || c == CH_LF || c == CH_CR || c == CH_QUOTE || blank_char(c));
		return c;
	endfunction

	// The body of a quoted field leans toward commas, line breaks and
	// doubled quotes.
	task automatic send_quoted_body(input int len);
		logic [7:0] c;
		for (int j = 0; j < len; j++) begin
			case ($urandom_range(0, 9))
				0: send_data(CH_COMMA);
				1: send_data(CH_LF);
				2: send_data(CH_CR);
				3: begin
					send_data(CH_QUOTE);
					send_data(CH_QUOTE);
				end
				default: begin
					c = pick_plain();
					send_data((c == CH_QUOTE) ? 8'h51 : c);
				end
			endcase
		end
	endtask

	// A run of well-formed fields with random content and no line ending.
	task automatic send_good_fields(input int nf);
		int len;
		logic [7:0] c;
		for (int i = 0; i < nf; i++) begin
			if (i > 0)
				send_data(CH_COMMA);
			if ($urandom_range(0, 2) == 0) begin
				send_data(CH_QUOTE);
				send_quoted_body($urandom_range(0, 6));
				send_data(CH_QUOTE);
				repeat ($urandom_range(0, 2)) send_data(pick_blank());
			end else begin
				len = $urandom_range(0, 6);
				for (int j = 0; j < len; j++) begin
					c = pick_plain();
					// A leading quote would turn the field into a quoted one.
					send_data((j == 0 && c == CH_QUOTE) ? 8'h41 : c);
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Directed tests.
	// ------------------------------------------------------------------------
	task automatic test_empty_lines();
		// An empty line gives one empty field. A CR at field start ends the
		// line at once. The byte after it and the end marker give nothing.
		send_end();
		send_data(CH_CR);
		send_data(8'h41);
		send_end();
		wait_drain();
	endtask

	task automatic test_plain_fields();
		// The byte extremes, a quote inside an unquoted field, an empty
		// field and a trailing comma that adds no field.
		send_data(8'h00);
		send_data(CH_COMMA);
		send_data(8'hFF);
		send_data(CH_QUOTE);
		send_data(CH_COMMA);
		send_data(CH_COMMA);
		send_end();
		wait_drain();
	endtask

	task automatic test_quoted_fields();
		// A quoted field that holds a CR, an LF, a comma and a doubled quote.
		// A tab follows the closing quote. Then comes an empty quoted field
		// that the end marker closes.
		send_str("\"\r\n,\"\"\"");
		send_data(CH_TAB);
		send_data(CH_COMMA);
		send_str("\"\"");
		send_end();
		wait_drain();
	endtask

	task automatic test_error_cases();
		// Junk after a closing quote. The bytes after it are dropped.
		send_str("\"a\" bc");
		send_end();
		// An end marker in an open quoted field, just after a doubled quote.
		send_str("\"x\"\"");
		send_end();
		wait_drain();
	endtask

	task automatic test_count_saturation();
		// More fields than the counter can hold. The later fields share
		// the saturated index, and an LF then ends the line.
		repeat (int'(FIELD_CAP) + 8) send_data(CH_COMMA);
		send_data(CH_LF);
		send_end();
		wait_drain();
	endtask

	// ------------------------------------------------------------------------
	// Random lines. Most are well-formed with random content. The rest are
	// broken lines and byte noise.
	// ------------------------------------------------------------------------
	task automatic test_random_lines();
		int target;
		int pick;
		target = n_items + RANDOM_ITEMS;
		while (n_items < target) begin
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				send_good_fields(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
				if ($urandom_range(0, 5) == 0)
					send_data(CH_COMMA);
				case ($urandom_range(0, 5))
					0: send_data(CH_LF);
					1: send_data(CH_CR);
					2: begin
						send_data(CH_CR);
						send_data(CH_LF);
					end
					default: ;
				endcase
				repeat ($urandom_range(0, 2)) send_data(pick_plain());
				send_end();
			end else if (pick < 17) begin
				send_good_fields($urandom_range(0, 2));
				if ($urandom_range(0, 1) == 0)
					send_data(CH_COMMA);
				send_data(CH_QUOTE);
				send_quoted_body($urandom_range(0, 4));
				if ($urandom_range(0, 1) == 0) begin
					// Junk after the closing quote, maybe after some blanks.
					send_data(CH_QUOTE);
					repeat ($urandom_range(0, 2)) send_data(pick_blank());
					send_data(pick_junk());
					repeat ($urandom_range(0, 3)) send_data(8'($urandom_range(0, 255)));
				end else if ($urandom_range(0, 1) == 0) begin
					// The field is left open right after a doubled quote.
					send_data(CH_QUOTE);
					send_data(CH_QUOTE);
				end
				send_end();
			end else begin
				repeat ($urandom_range(0, 12)) begin
					if ($urandom_range(0, 1) == 0) begin
						send_data(8'($urandom_range(0, 255)));
					end else begin
						case ($urandom_range(0, 4))
							0: send_data(CH_QUOTE);
							1: send_data(CH_COMMA);
							2: send_data(CH_LF);
							3: send_data(CH_CR);
							default: send_data(pick_blank());
						endcase
					end
				end
				send_end();
			end
			if ($urandom_range(0, 39) == 0)
				wait_drain();
		end
		wait_drain();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lines();
		test_plain_fields();
		test_quoted_fields();
		test_error_cases();
		test_count_saturation();
		test_random_lines();

		// Give the core time to show any result that nothing expects.
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in %0d lines; checked %0d results.",
			n_items, n_lines, n_checked);
		$display("That took in %0d line ends and %0d parse errors.",
			n_eol_seen, n_err_seen);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog. The slowest correct run is far below this bound.
	initial begin
		#2_000_000;
		$display("Timeout: %0d results still pending", pending_tokens.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
sv/csvlp_pkg.sv
sv/csvlp_front.sv
sv/csvlp_queue.sv
sv/csvlp_back.sv
sv/csv_line_field_parser_core.sv
bench/csv_line_field_parser_core_tb.sv
